FILE: rtl/core/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer table package
// Shared types and constants: request and result beats, table entry layout
// and the memory write bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

    // Number of timer slots; slot numbers are three bits wide.
    localparam int SLOTS = 8;
    localparam int IDX_W = 3;

    // Request codes.
    localparam logic [1:0] REQ_ARM    = 2'd0;
    localparam logic [1:0] REQ_DISARM = 2'd1;
    localparam logic [1:0] REQ_CHECK  = 2'd2;

    // A deadline counts as reached while now minus deadline lies below this.
    localparam logic [31:0] EXPIRY_WINDOW = 32'h7FFF_FFFF;
    // Largest accepted period; the all-ones period is saturated to it.
    localparam logic [30:0] PERIOD_LIMIT  = 31'h7FFF_FFFF;
    localparam logic [30:0] PERIOD_MAX    = 31'h7FFF_FFFE;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  slot_id;
        logic [30:0] period_ms;
        logic [31:0] now_ms;
        logic [7:0]  keep_mask;
    } t_req;

    typedef struct packed {
        logic [2:0] expired_slot;
        logic       last_expired;
    } t_rsp;

    // One table entry as held in the memory.
    typedef struct packed {
        logic [31:0] deadline;
        logic [30:0] period;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

endpackage

`default_nettype wire

FILE: rtl/core/ptt_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// Periodic timer table controller
// Armed flags, request decode, the slot scan with read-modify-write of the
// entry memory, and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ctrl
    import ptt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_stall,
    input  wire t_req             i_req,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_stall,
    output t_rsp                  o_rsp,
    output logic      [IDX_W-1:0] o_rd_addr,
    input  wire t_entry           i_rd_data,
    output t_mem_wr               o_wr
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} t_state;

    t_state            r_state;
    logic [SLOTS-1:0]  r_armed;
    logic [SLOTS-1:0]  r_mask;
    logic [SLOTS-1:0]  r_keep;
    logic [31:0]       r_now;
    logic [IDX_W-1:0]  r_idx;
    logic              r_rsp_valid;
    t_rsp              r_rsp;

    logic              accept;
    logic [30:0]       per_sat;
    logic [31:0]       diff;
    logic              hit;
    logic              kept;
    logic              out_free;
    logic              emit;
    logic [IDX_W-1:0]  low;
    logic [SLOTS-1:0]  rest;

    assign accept      = i_req_valid && (r_state == S_IDLE);
    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    assign per_sat = (i_req.period_ms == PERIOD_LIMIT) ? PERIOD_MAX : i_req.period_ms;

    // The entry of slot r_idx is on the memory output during the scan.
    assign diff = r_now - i_rd_data.deadline;
    assign hit  = r_armed[r_idx] && (diff < EXPIRY_WINDOW);
    assign kept = r_keep[r_idx];

    assign o_rd_addr = (r_state == S_SCAN) ? r_idx + IDX_W'(1) : '0;

    always_comb begin
        o_wr.we            = 1'b0;
        o_wr.addr          = i_req.slot_id;
        o_wr.data.deadline = i_req.now_ms + {1'b0, per_sat};
        o_wr.data.period   = per_sat;
        if (accept && (i_req.req_type == REQ_ARM)) begin
            o_wr.we = 1'b1;
        end else if ((r_state == S_SCAN) && hit && kept) begin
            o_wr.we            = 1'b1;
            o_wr.addr          = r_idx;
            o_wr.data.deadline = i_rd_data.deadline + {1'b0, i_rd_data.period};
            o_wr.data.period   = i_rd_data.period;
        end
    end

    // Lowest pending expiry is reported first.
    always_comb begin
        low = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low = IDX_W'(i);
            end
        end
    end

    assign rest     = r_mask & ~(SLOTS'(1) << low);
    assign out_free = !r_rsp_valid || !i_rsp_stall;
    assign emit     = (r_state == S_EMIT) && (r_mask != '0) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_rsp_valid <= 1'b1;
            end else if (r_rsp_valid && !i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_req.req_type)
                            REQ_ARM: begin
                                r_armed[i_req.slot_id] <= 1'b1;
                            end
                            REQ_DISARM: begin
                                r_armed[i_req.slot_id] <= 1'b0;
                            end
                            REQ_CHECK: begin
                                r_now   <= i_req.now_ms;
                                r_keep  <= i_req.keep_mask;
                                r_mask  <= '0;
                                r_idx   <= '0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_mask[r_idx] <= 1'b1;
                        if (!kept) begin
                            r_armed[r_idx] <= 1'b0;
                        end
                    end
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == IDX_W'(SLOTS - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_mask == '0) begin
                        r_state <= S_IDLE;
                    end else if (emit) begin
                        r_rsp.expired_slot <= low;
                        r_rsp.last_expired <= (rest == '0);
                        r_mask             <= rest;
                        if (rest == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/periodic_timer_table_unit.sv
// ----------------------------------------------------------------------------
// Periodic timer table unit
// Eight periodic millisecond timers with arm, disarm and expiry check.
// ----------------------------------------------------------------------------
// An arm beat writes the slot's period and a deadline of now plus period.
// For a check beat the scan reads one table entry per cycle from the entry
// memory through its single read port, and then one result beat per cycle,
// unless the receiver stalls, leaves through the output register in
// ascending slot order, the final one marked with last_expired. A slot
// expires when now minus its deadline, as an unsigned 32-bit difference,
// lies below 0x7FFFFFFF, so the comparison holds across wrap of the time
// base. A kept slot (its keep_mask bit set) moves its deadline on by one
// period; any other expired slot is disarmed. A period of all ones is
// saturated to 0x7FFFFFFE. Request code three is taken and ignored. New
// requests are held off while a check is in progress, but a request is
// taken while the last result beat still waits on the output.
`default_nettype none

module periodic_timer_table_unit
    import ptt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_stall,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_stall,
    output t_rsp      o_rsp
);

    // Interface between controller and entry memory.
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    t_mem_wr          wr;

    // The controller owns the armed flags and the scan sequence; the
    // deadlines and periods live in the memory and are read, updated and
    // written back one slot per cycle. A write-back to slot i during the scan
    // lands while slot i + 1 is being read, so the two never meet on one entry.
    ptt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr        (wr)
    );

    // Entries of slots never armed are read but never used, since only armed
    // slots can hit, so the memory needs no clearing after reset.
    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Periodic timer table unit testbench
// Drives arm, disarm and check beats into the timer table and predicts every
// expiry beat from a behavioural copy of the slot table kept in the bench.
// Each result beat is compared field by field with the oldest prediction.
// Directed beats come first, then random traffic with random idling on both
// sides, a long output hold-off and a final stretch with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import ptt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Request code three has no meaning; the block takes it and does nothing.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Cycles the receiver holds off in one go during the back-pressure test.
    localparam int unsigned RSP_HOLD_CYCLES = 300;
    // Cycles allowed after the last expected beat, for a check to scan every
    // slot and then emit its results.
    localparam int unsigned SETTLE_CYCLES = 2 * SLOTS + 4;
    // Hard limit on the run, far above the slowest legal run.
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    t_req i_req = '0;
    logic i_rsp_stall = 1'b0;
    logic o_req_stall;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // Behavioural copy of the slot table. Entries of slots never armed are
    // never read, since only armed slots take part in a check.
    logic [SLOTS-1:0] slot_armed = '0;
    logic [31:0]      slot_deadline [SLOTS];
    logic [30:0]      slot_period [SLOTS];

    // Expiry beats predicted but not yet seen on the output, oldest first.
    t_rsp pending_expiries [$];

    int unsigned mismatch_count = 0;

    // Millisecond time base that the well-formed traffic moves forward.
    logic [31:0] clock_ms = '0;

    // Idling control. These are written with nonblocking assignments from the
    // test sequence, so the idling processes never race with it.
    logic        idling_on = 1'b0;
    int unsigned hold_reqs = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned burst_left = 0;

    periodic_timer_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Applies one accepted request beat to the bench's slot table and queues
    // the expiry beats that it must cause. A check reads its time once and
    // walks the slots in ascending order; the final expiry carries the mark.
    task automatic predict_expiries(input t_req r);
        logic [30:0] per;
        logic [31:0] overdue;
        t_rsp        held;
        logic        have_held;
        begin
            per = (r.period_ms == PERIOD_LIMIT) ? PERIOD_MAX : r.period_ms;
            have_held = 1'b0;
            held = '0;
            case (r.req_type)
                REQ_ARM: begin
                    if (int'(r.slot_id) < SLOTS) begin
                        slot_armed[r.slot_id] = 1'b1;
                        slot_period[r.slot_id] = per;
                        slot_deadline[r.slot_id] = r.now_ms + {1'b0, per};
                    end
                end
                REQ_DISARM: begin
                    if (int'(r.slot_id) < SLOTS) begin
                        slot_armed[r.slot_id] = 1'b0;
                    end
                end
                REQ_CHECK: begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (slot_armed[s]) begin
                            // Unsigned difference keeps the test valid across
                            // wrap of the time base.
                            overdue = r.now_ms - slot_deadline[s];
                            if (overdue < EXPIRY_WINDOW) begin
                                if (r.keep_mask[s]) begin
                                    slot_deadline[s] = slot_deadline[s]
                                                       + {1'b0, slot_period[s]};
                                end else begin
                                    slot_armed[s] = 1'b0;
                                end
                                // The previous hit is now known not to be last.
                                if (have_held) begin
                                    pending_expiries.push_back(held);
                                end
                                held.expired_slot = IDX_W'(s);
                                held.last_expired = 1'b0;
                                have_held = 1'b1;
                            end
                        end
                    end
                    if (have_held) begin
                        held.last_expired = 1'b1;
                        pending_expiries.push_back(held);
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one request beat and returns at the edge where it was taken.
    // Valid is left high on return, so back-to-back beats never drop it; a
    // gap or a pause lowers it explicitly.
    task automatic send_req(input logic [1:0] kind, input logic [2:0] slot,
                            input logic [30:0] per, input logic [31:0] now,
                            input logic [7:0] keep);
        t_req r;
        begin
            r.req_type = kind;
            r.slot_id = slot;
            r.period_ms = per;
            r.now_ms = now;
            r.keep_mask = keep;
            if (idling_on && $urandom_range(0, 3) == 0) begin
                i_req_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            i_req_valid <= 1'b1;
            i_req <= r;
            do @(posedge i_clk); while (o_req_stall);
            predict_expiries(r);
        end
    endtask

    // The sender stops and waits until every predicted beat has come out.
    // It lowers valid before the wait, so valid always goes low.
    task automatic wait_for_expiries();
        begin
            i_req_valid <= 1'b0;
            do @(posedge i_clk); while (pending_expiries.size() != 0);
        end
    endtask

    // One random beat. Most of the traffic is well formed: arms against the
    // running time base and checks that move it forward, so that slots do
    // expire and get reloaded. The rest is disarms, checks at arbitrary
    // times and the unused request code.
    task automatic random_item();
        int unsigned pick;
        logic [30:0] per;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                if ($urandom_range(0, 15) == 0) begin
                    per = 31'($urandom);
                end else begin
                    per = 31'($urandom_range(0, 40));
                end
                send_req(REQ_ARM, 3'($urandom), per, clock_ms, 8'($urandom));
            end else if (pick < 40) begin
                send_req(REQ_DISARM, 3'($urandom), 31'($urandom), $urandom,
                         8'($urandom));
            end else if (pick < 86) begin
                clock_ms = clock_ms + $urandom_range(0, 30);
                send_req(REQ_CHECK, 3'($urandom), 31'($urandom), clock_ms,
                         8'($urandom));
            end else if (pick < 94) begin
                send_req(REQ_CHECK, 3'($urandom), 31'($urandom), $urandom,
                         8'($urandom));
            end else begin
                send_req(REQ_UNUSED, 3'($urandom), 31'($urandom), $urandom,
                         8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------

    // Receiver stall. A long hold-off, once asked for, is counted out here;
    // otherwise stalls come in random bursts while idling is on.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_reqs) begin
            i_rsp_stall <= 1'b1;
            hold_served <= hold_reqs;
            hold_left <= RSP_HOLD_CYCLES - 1;
        end else if (burst_left != 0) begin
            i_rsp_stall <= 1'b1;
            burst_left <= burst_left - 1;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            i_rsp_stall <= 1'b1;
            burst_left <= $urandom_range(0, 6);
        end else begin
            i_rsp_stall <= 1'b0;
        end
    end

    // Every accepted result beat is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (pending_expiries.size() == 0) begin
                $error("unexpected result beat: expired_slot %0d last_expired %0b",
                       o_rsp.expired_slot, o_rsp.last_expired);
                mismatch_count++;
            end else begin
                want = pending_expiries.pop_front();
                if (o_rsp.expired_slot !== want.expired_slot) begin
                    $error("expired_slot: expected %0d, got %0d",
                           want.expired_slot, o_rsp.expired_slot);
                    mismatch_count++;
                end
                if (o_rsp.last_expired !== want.last_expired) begin
                    $error("last_expired: expected %0b, got %0b",
                           want.last_expired, o_rsp.last_expired);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Arming, disarming, a check with nothing due, the unused request code,
    // a zero period that is kept at the same deadline, and saturation of the
    // all-ones period.
    task automatic test_arm_disarm_check();
        begin
            send_req(REQ_CHECK, 3'd0, 31'($urandom), 32'd0, 8'hFF);
            send_req(REQ_UNUSED, 3'd5, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
            send_req(REQ_ARM, 3'd0, 31'd0, 32'd1000, 8'($urandom));
            send_req(REQ_ARM, 3'd1, 31'd5, 32'd1000, 8'($urandom));
            send_req(REQ_ARM, 3'd2, 31'h7FFF_FFFF, 32'd1000, 8'($urandom));
            send_req(REQ_ARM, 3'd3, 31'h7FFF_FFFE, 32'd0, 8'($urandom));
            send_req(REQ_ARM, 3'd7, 31'd10, 32'd1000, 8'($urandom));
            send_req(REQ_DISARM, 3'd1, 31'($urandom), $urandom, 8'($urandom));
            // The zero-period slot is due at once and stays put when kept.
            send_req(REQ_CHECK, 3'($urandom), 31'($urandom), 32'd1000, 8'h01);
            send_req(REQ_CHECK, 3'($urandom), 31'($urandom), 32'd1010, 8'h00);
            send_req(REQ_DISARM, 3'd4, 31'($urandom), $urandom, 8'($urandom));
        end
    endtask

    // Both sides of the expiry window, a deadline across wrap of the time
    // base, and checks where every slot expires at once.
    task automatic test_expiry_window_and_wrap();
        begin
            send_req(REQ_ARM, 3'd5, 31'd0, 32'd0, 8'($urandom));
            // A difference of exactly the window is not yet expired.
            send_req(REQ_CHECK, 3'($urandom), 31'($urandom), 32'h7FFF_FFFF, 8'hFF);
            send_req(REQ_CHECK, 3'($urandom), 31'($urandom), 32'h7FFF_FFFE, 8'h00);
            send_req(REQ_ARM, 3'd6, 31'h20, 32'hFFFF_FFF0, 8'($urandom));
            send_req(REQ_CHECK, 3'($urandom), 31'($urandom), 32'h0000_000F, 8'hFF);
            send_req(REQ_CHECK, 3'($urandom), 31'($urandom), 32'h0000_0010, 8'hBF);
            for (int s = 0; s < SLOTS; s++) begin
                send_req(REQ_ARM, 3'(s), 31'($urandom_range(0, 3)), 32'd5000,
                         8'($urandom));
            end
            send_req(REQ_CHECK, 3'($urandom), 31'($urandom), 32'd6000, 8'hFF);
            send_req(REQ_CHECK, 3'($urandom), 31'($urandom), 32'd6000, 8'h00);
        end
    endtask

    // Random traffic with idling on both sides. Half the time the time base
    // starts just short of wrap so that deadlines straddle it.
    task automatic test_random_traffic();
        begin
            idling_on <= 1'b1;
            clock_ms = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FE00 : $urandom;
            repeat (100) random_item();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering checks that expire every slot, so the table backs up and
    // stalls its request side. The sender then pauses until all is out.
    task automatic test_output_backpressure();
        begin
            hold_reqs <= hold_reqs + 1;
            for (int s = 0; s < SLOTS; s++) begin
                send_req(REQ_ARM, 3'(s), 31'd1, clock_ms, 8'($urandom));
            end
            repeat (6) begin
                clock_ms = clock_ms + $urandom_range(1, 3);
                send_req(REQ_CHECK, 3'($urandom), 31'($urandom), clock_ms, 8'hFF);
            end
            wait_for_expiries();
        end
    endtask

    // A closing stretch of random traffic with no idling on either side.
    task automatic test_quiet_tail();
        begin
            idling_on <= 1'b0;
            repeat (20) random_item();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_arm_disarm_check();
        test_expiry_window_and_wrap();
        test_random_traffic();
        test_output_backpressure();
        test_quiet_tail();

        wait_for_expiries();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_expiries.size() != 0) begin
            $error("%0d expiry beats never arrived", pending_expiries.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Guards against a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $error("run limit reached with %0d expiry beats outstanding",
               pending_expiries.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
